@@ hw/rtl/npcs_pkg.sv @@
// ----------------------------------------------------------------------------
// npcs_pkg: nearest palette color search types and constants
// Command codes and the input and result transaction layouts.
// ----------------------------------------------------------------------------
package npcs_pkg;

	localparam int CMD_W       = 2;
	localparam int INDEX_W     = 8;
	localparam int CHAN_W      = 6;
	localparam int PACKED_W    = 15;
	localparam int PACKED_CH_W = 5;

	localparam logic [CMD_W-1:0] CMD_WRITE         = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_RGB    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_PACKED = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [INDEX_W-1:0]  entry_index;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [PACKED_W-1:0] packed_colour;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] nearest_idx;
	} out_item_t;

endpackage

@@ hw/rtl/npcs_stream_if.sv @@
// ----------------------------------------------------------------------------
// npcs_stream_if: valid/ready stream channel
// One transaction moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface npcs_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/nearest_palette_color_search_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit: nearest palette entry by squared distance
// Palette store with one pipelined distance unit that scans the entries.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)   : write and lookup commands. A write stores one palette
//                     entry and gives no result. Command 3 is dropped.
//   out_ch (source) : one nearest_idx transaction per lookup.
//   A lookup reads one palette entry per cycle from the store's read port
//   through a four-stage distance pipeline (read, difference, square,
//   sum and compare). in_ch is not ready while the scan runs and takes
//   the next command once the result has moved to the output register,
//   so a new lookup is not taken before the last one is through.
//   After reset the store is swept to zero, one entry per cycle; in_ch is
//   not ready during the sweep.
//   The result sits in an output register, so in_ch takes new commands while
//   it waits. A finished scan holds its result until out_ch has room.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_unit #(
	parameter int PALETTE_DEPTH = 256,
	parameter int SEARCH_LIMIT  = 254,
	parameter int CHANNEL_BITS  = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	npcs_stream_if.sink     in_ch,
	npcs_stream_if.source   out_ch
);

	localparam int AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CB     = CHANNEL_BITS;
	localparam int EW     = 3 * CB;
	localparam int SQW    = 2 * CB;
	localparam int DISTW  = 2 * CB + 2;
	localparam int LIM0   = (SEARCH_LIMIT < PALETTE_DEPTH) ? SEARCH_LIMIT : PALETTE_DEPTH;
	localparam int LIMIT  = (LIM0 < 1) ? 1 : LIM0;
	localparam logic [AW-1:0] SCAN_LAST  = AW'(LIMIT - 1);
	localparam logic [AW-1:0] CLEAR_LAST = AW'(PALETTE_DEPTH - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic          issue_q;
	logic          v_s1, v_s2, v_s3;
	logic          out_valid_q;
	npcs_pkg::out_item_t out_q;

	logic [EW-1:0] mem [PALETTE_DEPTH];

	logic [CB-1:0] qr_q, qg_q, qb_q;
	logic [EW-1:0] rd_s1;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [CB-1:0] dr_s2, dg_s2, db_s2;
	logic [SQW-1:0] sr_s3, sg_s3, sb_s3;
	logic [DISTW-1:0] best_dist_q;
	logic [AW-1:0]    best_idx_q;

	logic          accept;
	logic          is_write;
	logic          is_lookup;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic [CB-1:0] q_r, q_g, q_b;
	logic [CB-1:0] e_r, e_g, e_b;
	logic [DISTW-1:0] sum_sq;
	logic          take_best;
	logic          slot_free;

	function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_write    = (in_ch.payload.cmd == npcs_pkg::CMD_WRITE);
	assign is_lookup   = (in_ch.payload.cmd == npcs_pkg::CMD_LOOKUP_RGB) ||
	                     (in_ch.payload.cmd == npcs_pkg::CMD_LOOKUP_PACKED);

	always_comb begin
		case (in_ch.payload.cmd)
			npcs_pkg::CMD_LOOKUP_PACKED: begin
				q_r = CB'({in_ch.payload.packed_colour[14:10], 1'b0});
				q_g = CB'({in_ch.payload.packed_colour[9:5], 1'b0});
				q_b = CB'({in_ch.payload.packed_colour[4:0], 1'b0});
			end
			default: begin
				q_r = CB'(in_ch.payload.red);
				q_g = CB'(in_ch.payload.green);
				q_b = CB'(in_ch.payload.blue);
			end
		endcase
	end

	// store port: zero sweep after reset, else command writes
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
			wr_data = '0;
		end else begin
			wr_en   = accept && is_write &&
			          (32'(in_ch.payload.entry_index) < 32'(PALETTE_DEPTH));
			wr_addr = AW'(in_ch.payload.entry_index);
			wr_data = {CB'(in_ch.payload.red), CB'(in_ch.payload.green),
			           CB'(in_ch.payload.blue)};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[cnt_q];
	end

	assign e_r = rd_s1[EW-1 -: CB];
	assign e_g = rd_s1[2*CB-1 -: CB];
	assign e_b = rd_s1[CB-1:0];

	assign sum_sq = DISTW'(sr_s3) + DISTW'(sg_s3) + DISTW'(sb_s3);
	assign take_best = v_s3 && ((idx_s3 == '0) || (sum_sq < best_dist_q));
	assign slot_free = !out_valid_q || out_ch.ready;

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && is_lookup) begin
			qr_q <= q_r;
			qg_q <= q_g;
			qb_q <= q_b;
		end
		idx_s1 <= cnt_q;
		idx_s2 <= idx_s1;
		dr_s2  <= abs_diff(qr_q, e_r);
		dg_s2  <= abs_diff(qg_q, e_g);
		db_s2  <= abs_diff(qb_q, e_b);
		idx_s3 <= idx_s2;
		sr_s3  <= SQW'(dr_s2) * SQW'(dr_s2);
		sg_s3  <= SQW'(dg_s2) * SQW'(dg_s2);
		sb_s3  <= SQW'(db_s2) * SQW'(db_s2);
		if (take_best) begin
			best_dist_q <= sum_sq;
			best_idx_q  <= idx_s3;
		end
		if (state_q == ST_HOLD && slot_free) begin
			out_q.nearest_idx <= npcs_pkg::INDEX_W'(best_idx_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN) && issue_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (state_q == ST_HOLD && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == CLEAR_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept && is_lookup) begin
						cnt_q   <= '0;
						issue_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (cnt_q == SCAN_LAST) begin
							issue_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (v_s3 && idx_s3 == SCAN_LAST) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: nearest palette color search unit testbench
// Drives palette writes, unused commands and both lookup forms on in_ch and
// predicts the nearest searched entry (squared distance, lowest index on a tie)
// from a private copy of the palette. Results on out_ch are checked in order;
// both channels idle at random, except in the last of three phases, which has none.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [npcs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int PAL_ENTRIES  = 256;
	localparam int SEARCH_DEPTH = 254;
	localparam int RANDOM_ITEMS = 480;
	localparam int DRAIN_CYCLES = 270;

	// Palette shadow, nearest-entry predictor and in-order result check.
	class palette_scoreboard;
		logic [npcs_pkg::CHAN_W-1:0]  pal_r [PAL_ENTRIES];
		logic [npcs_pkg::CHAN_W-1:0]  pal_g [PAL_ENTRIES];
		logic [npcs_pkg::CHAN_W-1:0]  pal_b [PAL_ENTRIES];
		logic [npcs_pkg::INDEX_W-1:0] exp_idx_q [$];
		int errors, n_write, n_rgb, n_packed, n_dropped, n_checked;

		function new();
			foreach (pal_r[i]) begin
				pal_r[i] = '0;
				pal_g[i] = '0;
				pal_b[i] = '0;
			end
		endfunction

		function int pending();
			return exp_idx_q.size();
		endfunction

		function logic [npcs_pkg::INDEX_W-1:0] nearest_entry(
				logic [npcs_pkg::CHAN_W-1:0] r, logic [npcs_pkg::CHAN_W-1:0] g,
				logic [npcs_pkg::CHAN_W-1:0] b);
			int best, best_dist, sq_sum, dr, dg, db;
			best = 0;
			best_dist = 0;
			for (int i = 0; i < SEARCH_DEPTH; i++) begin
				dr = int'(r) - int'(pal_r[i]);
				dg = int'(g) - int'(pal_g[i]);
				db = int'(b) - int'(pal_b[i]);
				sq_sum = dr * dr + dg * dg + db * db;
				if (i == 0 || sq_sum < best_dist) begin
					best_dist = sq_sum;
					best = i;
				end
			end
			return best[npcs_pkg::INDEX_W-1:0];
		endfunction

		function void note_input(npcs_pkg::in_item_t t);
			case (t.cmd)
				npcs_pkg::CMD_WRITE: begin
					pal_r[t.entry_index] = t.red;
					pal_g[t.entry_index] = t.green;
					pal_b[t.entry_index] = t.blue;
					n_write++;
				end
				npcs_pkg::CMD_LOOKUP_RGB: begin
					exp_idx_q.push_back(nearest_entry(t.red, t.green, t.blue));
					n_rgb++;
				end
				npcs_pkg::CMD_LOOKUP_PACKED: begin
					exp_idx_q.push_back(nearest_entry({t.packed_colour[14:10], 1'b0},
						{t.packed_colour[9:5], 1'b0}, {t.packed_colour[4:0], 1'b0}));
					n_packed++;
				end
				default: n_dropped++;
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(npcs_pkg::out_item_t o);
			logic [npcs_pkg::INDEX_W-1:0] exp_idx;
			if (exp_idx_q.size() == 0) begin
				report($sformatf("nearest_idx %0d with no lookup pending", o.nearest_idx));
			end else begin
				exp_idx = exp_idx_q.pop_front();
				n_checked++;
				if (o.nearest_idx !== exp_idx)
					report($sformatf("nearest_idx %0d, expected %0d", o.nearest_idx, exp_idx));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle;
	int   rx_idle;
	palette_scoreboard sb;

	npcs_stream_if #(.T(npcs_pkg::in_item_t))  in_ch ();
	npcs_stream_if #(.T(npcs_pkg::out_item_t)) out_ch ();

	nearest_palette_color_search_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("nearest_palette_color_search_unit test failed");
		$finish;
	end

	// Result sink with random backpressure.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.payload);
	end

	function automatic npcs_pkg::in_item_t mk_item(logic [npcs_pkg::CMD_W-1:0] cmd,
			logic [npcs_pkg::INDEX_W-1:0] idx, logic [npcs_pkg::CHAN_W-1:0] r,
			logic [npcs_pkg::CHAN_W-1:0] g, logic [npcs_pkg::CHAN_W-1:0] b,
			logic [npcs_pkg::PACKED_W-1:0] pc);
		npcs_pkg::in_item_t t;
		t.cmd           = cmd;
		t.entry_index   = npcs_pkg::INDEX_W'($urandom_range(255));
		t.red           = npcs_pkg::CHAN_W'($urandom_range(63));
		t.green         = npcs_pkg::CHAN_W'($urandom_range(63));
		t.blue          = npcs_pkg::CHAN_W'($urandom_range(63));
		t.packed_colour = npcs_pkg::PACKED_W'($urandom_range(32767));
		case (cmd)
			npcs_pkg::CMD_WRITE: begin
				t.entry_index = idx;
				t.red   = r;
				t.green = g;
				t.blue  = b;
			end
			npcs_pkg::CMD_LOOKUP_RGB: begin
				t.red   = r;
				t.green = g;
				t.blue  = b;
			end
			npcs_pkg::CMD_LOOKUP_PACKED: t.packed_colour = pc;
			default: ;
		endcase
		return t;
	endfunction

	// Mix of writes, duplicate-colour writes (ties), exact-hit and random lookups.
	function automatic npcs_pkg::in_item_t random_item();
		npcs_pkg::in_item_t t;
		int sel, k;
		t = mk_item(CMD_UNUSED, 0, 0, 0, 0, 0);
		sel = $urandom_range(99);
		k = $urandom_range(SEARCH_DEPTH - 1);
		if (sel < 5) begin
			t.cmd = CMD_UNUSED;
		end else if (sel < 50) begin
			t.cmd = npcs_pkg::CMD_WRITE;
			if (sel < 8)
				t.entry_index = npcs_pkg::INDEX_W'(SEARCH_DEPTH + $urandom_range(1));
			if (sel < 18) begin
				t.red   = sb.pal_r[k];
				t.green = sb.pal_g[k];
				t.blue  = sb.pal_b[k];
			end
		end else if (sel < 75) begin
			t.cmd = npcs_pkg::CMD_LOOKUP_RGB;
			if (sel < 62) begin
				t.red   = sb.pal_r[k];
				t.green = sb.pal_g[k];
				t.blue  = sb.pal_b[k];
			end
		end else begin
			t.cmd = npcs_pkg::CMD_LOOKUP_PACKED;
		end
		return t;
	endfunction

	// Entered and left at a falling edge.
	task send_item(npcs_pkg::in_item_t t);
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= t;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_input(t);
		@(negedge clk);
	endtask

	// Entered at a falling edge, left at a later one.
	task wait_drained();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		sb = new();
		tx_idle = 24;
		rx_idle = 67;
		arst_n <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.payload <= '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset palette, then entries above and at the last index of the search range
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_RGB, 0, 63, 63, 63, 0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_PACKED, 0, 0, 0, 0, 15'h7FFF));
		send_item(mk_item(npcs_pkg::CMD_WRITE, 255, 63, 63, 63, 0));
		send_item(mk_item(npcs_pkg::CMD_WRITE, 254, 63, 63, 63, 0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_RGB, 0, 63, 63, 63, 0));
		send_item(mk_item(npcs_pkg::CMD_WRITE, 253, 63, 63, 63, 0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_RGB, 0, 63, 63, 63, 0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_PACKED, 0, 0, 0, 0, 15'h7FFF));
		send_item(mk_item(npcs_pkg::CMD_WRITE, 0, 63, 0, 0, 0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_RGB, 0, 0, 0, 0, 0));
		send_item(mk_item(CMD_UNUSED, 0, 0, 0, 0, 0));
		// equal colours at two indexes
		send_item(mk_item(npcs_pkg::CMD_WRITE, 100, 0, 63, 0, 0));
		send_item(mk_item(npcs_pkg::CMD_WRITE, 50, 0, 63, 0, 0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_RGB, 0, 0, 63, 0, 0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_PACKED, 0, 0, 0, 0, 15'h03E0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_PACKED, 0, 0, 0, 0, 15'h7C00));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_PACKED, 0, 0, 0, 0, 15'h001F));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_PACKED, 0, 0, 0, 0, 15'h0000));
		send_item(mk_item(npcs_pkg::CMD_WRITE, 2, 1, 2, 3, 0));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_PACKED, 0, 0, 0, 0, 15'h0421));
		send_item(mk_item(npcs_pkg::CMD_LOOKUP_RGB, 0, 0, 0, 0, 0));
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 24 : (ph == 1) ? 67 : 0;
			rx_idle = (ph == 0) ? 67 : (ph == 1) ? 24 : 0;
			repeat (RANDOM_ITEMS / 3)
				send_item(random_item());
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d palette writes, %0d channel lookups, %0d packed lookups,",
			sb.n_write, sb.n_rgb, sb.n_packed);
		$display("%0d unused commands; %0d results checked, %0d mismatches",
			sb.n_dropped, sb.n_checked, sb.errors);
		if (sb.errors == 0)
			$display("nearest_palette_color_search_unit test passed");
		else
			$display("nearest_palette_color_search_unit test failed");
		$finish;
	end

endmodule
